### rtl/core/rau_pkg.sv
// Package with shared types and constants of the rational arithmetic unit.
`default_nettype none
package rau_pkg;
  localparam int unsigned ValueWidthDefault = 32;
  localparam int unsigned WideWidth = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_EQ  = 3'd4, OP_NE  = 3'd5, OP_GT  = 3'd6, OP_LT  = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  // Word passed from the front part to the back part.
  typedef struct packed {
    logic                 direct;
    logic                 truth;
    status_t              status;
    logic                 neg;
    logic [WideWidth-1:0] nm;
    logic [WideWidth-1:0] dm;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_GCD, BK_DIVN, BK_DIVD, BK_CHECK, BK_DONE
  } back_state_t;
endpackage
`default_nettype wire

### rtl/core/rau_front.sv
// Front part: multiplies operands, classifies the item and forms magnitudes.
`default_nettype none
module rau_front
  import rau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] a_num,
  input  wire logic [30:0] a_den,
  input  wire logic [31:0] b_num,
  input  wire logic [30:0] b_den,
  output logic             job_valid,
  input  wire logic        job_ready,
  output job_t             job
);
  // Stage one holds the operands, stage two the four products.
  logic        s1_valid;
  opcode_t     s1_op;
  logic        s1_zero;
  logic signed [31:0] s1_an, s1_bn;
  logic signed [32:0] s1_ad, s1_bd;
  logic        s2_valid;
  opcode_t     s2_op;
  logic        s2_zero;
  logic signed [WideWidth-1:0] p_anbd, p_adbn, p_anbn, p_adbd;
  logic        s2_go, s1_go;

  assign s2_go = !job_valid || job_ready;
  assign s1_go = !s2_valid || s2_go;
  assign full  = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!full) begin
      s1_valid <= push;
    end
    if (!full && push) begin
      s1_op   <= opcode_t'(opcode);
      s1_zero <= (a_den == '0) || (b_den == '0);
      s1_an   <= a_num;
      s1_bn   <= b_num;
      s1_ad   <= {2'b00, a_den};
      s1_bd   <= {2'b00, b_den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_go) begin
      s2_valid <= s1_valid;
    end
    if (s1_go && s1_valid) begin
      s2_op   <= s1_op;
      s2_zero <= s1_zero;
      p_anbd  <= WideWidth'(s1_an * s1_bd);
      p_adbn  <= WideWidth'(s1_ad * s1_bn);
      p_anbn  <= WideWidth'(s1_an * s1_bn);
      p_adbd  <= WideWidth'(s1_ad * s1_bd);
    end
  end

  // Classification and sign handling.
  job_t j;
  logic signed [WideWidth-1:0] num, den;
  always_comb begin
    j = '0;
    num = '0;
    den = p_adbd;
    case (s2_op)
      OP_ADD: num = p_anbd + p_adbn;
      OP_SUB: num = p_anbd - p_adbn;
      OP_MUL: num = p_anbn;
      OP_DIV: begin
        num = p_anbd;
        den = p_adbn;
      end
      default: num = '0;
    endcase
    j.status = ST_OK;
    if (s2_zero || (s2_op == OP_DIV && p_adbn == '0)) begin
      j.direct = 1'b1;
      j.status = ST_ZERO_DEN;
    end else if (s2_op inside {OP_EQ, OP_NE, OP_GT, OP_LT}) begin
      j.direct = 1'b1;
      case (s2_op)
        OP_EQ:   j.truth = (p_anbd == p_adbn);
        OP_NE:   j.truth = (p_anbd != p_adbn);
        OP_GT:   j.truth = (p_anbd > p_adbn);
        default: j.truth = (p_anbd < p_adbn);
      endcase
    end
    j.neg = (num[WideWidth-1] != den[WideWidth-1]) && (num != '0);
    j.nm  = num[WideWidth-1] ? -num : num;
    j.dm  = den[WideWidth-1] ? -den : den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (s2_go) begin
      job_valid <= s2_valid;
    end
    if (s2_go && s2_valid) begin
      job <= j;
    end
  end
endmodule
`default_nettype wire

### rtl/core/rau_back.sv
// Back part: binary gcd, two serial divisions and range check.
`default_nettype none
module rau_back
  import rau_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        job_valid,
  output logic             job_ready,
  input  job_t             job,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      res_num,
  output logic [30:0]      res_den,
  output logic             truth,
  output logic [1:0]       status
);
  localparam int CntW = $clog2(WideWidth + 1);
  localparam logic [WideWidth-1:0] Limit = WideWidth'(1) << (VALUE_WIDTH - 1);

  back_state_t state, state_next;
  logic [WideWidth-1:0] x, y, g, nm, dm, quo, rem;
  logic [CntW-1:0] shift, bits;
  logic neg;

  assign job_ready = (state == BK_IDLE);
  assign empty     = (state != BK_DONE);

  // Subtract step of the shift-subtract divider by g.
  logic [WideWidth:0] rtry;
  logic [WideWidth-1:0] quo_step, rem_step;
  always_comb begin
    rtry = {rem, quo[WideWidth-1]} - {1'b0, g};
    quo_step = {quo[WideWidth-2:0], !rtry[WideWidth]};
    rem_step = rtry[WideWidth] ? {rem[WideWidth-2:0], quo[WideWidth-1]}
                               : rtry[WideWidth-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (job_valid) state_next = job.direct ? BK_DONE : BK_GCD;
      BK_GCD:   if (y == '0 || x == '0) state_next = BK_DIVN;
      BK_DIVN:  if (bits == CntW'(1)) state_next = BK_DIVD;
      BK_DIVD:  if (bits == CntW'(1)) state_next = BK_CHECK;
      BK_CHECK: state_next = BK_DONE;
      BK_DONE:  if (pop) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  logic [WideWidth-1:0] gg;
  always_comb gg = (x == '0 ? y : x) << shift;

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: if (job_valid) begin
        res_num <= '0;
        res_den <= 31'd1;
        truth   <= job.truth;
        status  <= job.status;
        neg <= job.neg;
        nm  <= job.nm;
        dm  <= job.dm;
        x <= job.nm;
        y <= job.dm;
        shift <= '0;
      end
      BK_GCD: begin
        // Stein's algorithm, one step per cycle.
        if (y == '0 || x == '0) begin
          g <= gg;
          quo <= nm;
          rem <= '0;
          bits <= CntW'(WideWidth);
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          shift <= shift + CntW'(1);
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x >= y) begin
          x <= (x - y) >> 1;
        end else begin
          y <= (y - x) >> 1;
        end
      end
      BK_DIVN, BK_DIVD: begin
        if (bits != CntW'(1)) begin
          quo  <= quo_step;
          rem  <= rem_step;
          bits <= bits - CntW'(1);
        end else if (state == BK_DIVN) begin
          // Numerator done; start on the denominator.
          nm   <= quo_step;
          quo  <= dm;
          rem  <= '0;
          bits <= CntW'(WideWidth);
        end else begin
          dm <= quo_step;
        end
      end
      BK_CHECK: begin
        // Range check and final sign.
        if (dm > Limit - 1 || (neg ? nm > Limit : nm > Limit - 1)) begin
          status <= ST_OVERFLOW;
        end else begin
          res_num <= neg ? 32'(-nm) : 32'(nm);
          res_den <= 31'(dm);
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// Usage: write a word with push while full is low: opcode and two
// fractions. One result word appears with empty low; take it with pop.
// The front part registers operands, then forms four 32x33 products in
// one stage and classifies the word (errors, compares, arithmetic).
// A one-word handoff register separates it from the back part.
// The back part runs a binary gcd, one step per cycle, then two
// shift-subtract divisions by the gcd, and a range check. Errors and
// compares skip all three and go straight to the result.
// The gcd loop and the serial divider set the rate; one word is in the
// back part at a time while the front part may hold the next ones.
// Synchronous reset empties all stages. When the receiver does not pop,
// the result holds and the front part fills, then raises full.
`default_nettype none
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] a_num,
  input  wire logic [30:0] a_den,
  input  wire logic [31:0] b_num,
  input  wire logic [30:0] b_den,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      res_num,
  output logic [30:0]      res_den,
  output logic             truth,
  output logic [1:0]       status
);
  logic job_valid, job_ready;
  job_t job;

  rau_front u_front (
    .clk, .rst, .push, .full, .opcode, .a_num, .a_den, .b_num, .b_den,
    .job_valid, .job_ready, .job
  );

  rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .empty, .pop, .res_num, .res_den, .truth, .status
  );

  // A shown result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(res_num) && $stable(status)))
    else $error("result changed while waiting");

  // A true compare result carries no error and a zero numerator.
  a_truth: assert property (@(posedge clk) disable iff (rst)
    (!empty && truth) |-> (status == ST_OK && res_num == '0))
    else $error("truth with bad payload");

  // The handoff is taken only when the back part is idle.
  a_hand: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job_ready) |-> empty)
    else $error("handoff while result pending");
endmodule
`default_nettype wire

### tb/rational_arithmetic_unit_tb.sv
// Self-checking testbench for the rational arithmetic unit: directed table plus random words.
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        truth;
    logic [1:0]  status;
  } fraction_result_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] a_num;
    logic [30:0] a_den;
    logic [31:0] b_num;
    logic [30:0] b_den;
    logic        known;
    fraction_result_t res;
  } stim_row_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic [2:0] opcode;
  logic [31:0] a_num;
  logic [30:0] a_den;
  logic [31:0] b_num;
  logic [30:0] b_den;
  logic empty;
  logic pop;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic truth;
  logic [1:0] status;

  fraction_result_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int idle_cycles = 0;
  bit sending_done = 0;
  bit calm_phase = 0;
  bit hold_pop = 0;
  int pop_hold_left = 0;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 300;

  rational_arithmetic_unit DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .empty(empty), .pop(pop), .res_num(res_num), .res_den(res_den),
    .truth(truth), .status(status)
  );

  // Clock generation.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Euclid on 64-bit magnitudes; gcd of zero and n is n.
  function automatic logic [63:0] gcd_wide(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Predicts the reduced fraction, compare outcome and status of one word.
  function automatic fraction_result_t predict_fraction(
      logic [2:0] op, logic [31:0] an_in, logic [30:0] ad_in,
      logic [31:0] bn_in, logic [30:0] bd_in);
    fraction_result_t r;
    longint an, ad, bn, bd, num, den, lhs, rhs;
    logic [63:0] nm, dm, g;
    bit neg;
    bit t;
    an = longint'($signed(an_in));
    bn = longint'($signed(bn_in));
    ad = longint'({1'b0, ad_in});
    bd = longint'({1'b0, bd_in});
    r = '{num: 32'd0, den: 31'd1, truth: 1'b0, status: ST_OK};
    if (ad == 0 || bd == 0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    if (op >= OP_EQ) begin
      lhs = an * bd;
      rhs = bn * ad;
      case (op)
        OP_EQ: t = (lhs == rhs);
        OP_NE: t = (lhs != rhs);
        OP_GT: t = (lhs > rhs);
        default: t = (lhs < rhs);
      endcase
      r.truth = t;
      return r;
    end
    case (op)
      OP_ADD: begin
        num = an * bd + ad * bn;
        den = ad * bd;
      end
      OP_SUB: begin
        num = an * bd - ad * bn;
        den = ad * bd;
      end
      OP_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        if (bn == 0) begin
          r.status = ST_ZERO_DEN;
          return r;
        end
        num = an * bd;
        den = ad * bn;
      end
    endcase
    neg = ((num < 0) != (den < 0)) && num != 0;
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    g = gcd_wide(nm, dm);
    nm = nm / g;
    dm = dm / g;
    if (dm > 64'h7FFF_FFFF || (neg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF)) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    r.num = neg ? -nm[31:0] : nm[31:0];
    r.den = dm[30:0];
    return r;
  endfunction

  // Offers one word, waits for acceptance and records its expected result.
  task automatic send_word(stim_row_t row);
    fraction_result_t want;
    want = predict_fraction(row.opcode, row.a_num, row.a_den, row.b_num, row.b_den);
    if (row.known && want != row.res) begin
      $display("%0t: table row disagrees with prediction: table %h predicted %h",
               $time, row.res, want);
      errors++;
    end
    push <= 1'b1;
    opcode <= row.opcode;
    a_num <= row.a_num;
    a_den <= row.a_den;
    b_num <= row.b_num;
    b_den <= row.b_den;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_results.push_back(row.known ? row.res : want);
    words_sent++;
  endtask

  // Random idle burst on the sending side.
  task automatic sender_gap();
    int n;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      n = $urandom_range(1, 16);
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_num();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 40)) - 20);
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(0, 6))
      0: return 31'd0;
      1: return 31'h7FFF_FFFF;
      2: return 31'd1;
      3, 4: return 31'($urandom_range(1, 60));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t row;
    row = '0;
    row.opcode = 3'($urandom_range(0, 7));
    row.a_num = pick_num();
    row.a_den = pick_den();
    row.b_num = pick_num();
    row.b_den = pick_den();
    // Make equal values written differently show up now and then.
    if ($urandom_range(0, 7) == 0 && row.a_den != 0 && row.a_den < 31'd1000) begin
      row.b_num = row.a_num * 3;
      row.b_den = row.a_den * 3;
      if (row.a_num[31] || row.a_num > 32'd100000) row.b_num = row.a_num;
      if (row.a_num[31] || row.a_num > 32'd100000) row.b_den = row.a_den;
    end
    return row;
  endfunction

  function automatic stim_row_t mk(logic [2:0] op, logic [31:0] an, logic [30:0] ad,
                                   logic [31:0] bn, logic [30:0] bd, logic known,
                                   logic [31:0] rn, logic [30:0] rd, logic rt,
                                   logic [1:0] rs);
    stim_row_t row;
    row.opcode = op;
    row.a_num = an;
    row.a_den = ad;
    row.b_num = bn;
    row.b_den = bd;
    row.known = known;
    row.res = '{num: rn, den: rd, truth: rt, status: rs};
    return row;
  endfunction

  // Result side: random pops, one long hold, field-by-field compare.
  always @(posedge clk) begin
    fraction_result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (!empty && pop) begin
        idle_cycles <= 0;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word: num %h den %h truth %b status %0d",
                   $time, res_num, res_den, truth, status);
          errors++;
        end else begin
          want = pending_results.pop_front();
          words_checked++;
          if (res_num !== want.num) begin
            $display("%0t: res_num mismatch: expected %h actual %h", $time, want.num, res_num);
            errors++;
          end
          if (res_den !== want.den) begin
            $display("%0t: res_den mismatch: expected %h actual %h", $time, want.den, res_den);
            errors++;
          end
          if (truth !== want.truth) begin
            $display("%0t: truth mismatch: expected %b actual %b", $time, want.truth, truth);
            errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, status);
            errors++;
          end
        end
      end else if (!(push && !full)) begin
        idle_cycles <= idle_cycles + 1;
      end else begin
        idle_cycles <= 0;
      end
      // Pop control: a long hold on request, else random bursts of stall.
      if (hold_pop) begin
        pop_hold_left <= 3000;
        hold_pop <= 1'b0;
        pop <= 1'b0;
      end else if (pop_hold_left > 0) begin
        pop_hold_left <= pop_hold_left - 1;
        pop <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        pop_hold_left <= $urandom_range(1, 16);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if (!rst && idle_cycles >= WatchdogLimit) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    int wait_count;
    rst = 1'b1;
    push = 1'b0;
    opcode = OP_ADD;
    a_num = '0;
    a_den = 31'd1;
    b_num = '0;
    b_den = 31'd1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: fixed rows carry their result, the rest go to the predictor.
    table_rows.push_back(mk(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3, 1, 32'd5, 31'd6, 0, ST_OK));
    table_rows.push_back(mk(OP_SUB, 32'd1, 31'd2, 32'd1, 31'd2, 1, 32'd0, 31'd1, 0, ST_OK));
    table_rows.push_back(mk(OP_MUL, 32'd2, 31'd4, -32'd3, 31'd9, 1, -32'd1, 31'd6, 0, ST_OK));
    table_rows.push_back(mk(OP_DIV, 32'd1, 31'd2, -32'd1, 31'd4, 1, -32'd2, 31'd1, 0, ST_OK));
    table_rows.push_back(mk(OP_DIV, 32'd5, 31'd7, 32'd0, 31'd3, 1, 32'd0, 31'd1, 0,
                            ST_ZERO_DEN));
    table_rows.push_back(mk(OP_ADD, 32'd1, 31'd0, 32'd1, 31'd1, 1, 32'd0, 31'd1, 0,
                            ST_ZERO_DEN));
    table_rows.push_back(mk(OP_LT, 32'd1, 31'd1, 32'd1, 31'd0, 1, 32'd0, 31'd1, 0,
                            ST_ZERO_DEN));
    table_rows.push_back(mk(OP_EQ, 32'd2, 31'd4, 32'd1, 31'd2, 1, 32'd0, 31'd1, 1, ST_OK));
    table_rows.push_back(mk(OP_NE, 32'd2, 31'd4, 32'd1, 31'd2, 1, 32'd0, 31'd1, 0, ST_OK));
    table_rows.push_back(mk(OP_GT, 32'd1, 31'd2, 32'd1, 31'd3, 1, 32'd0, 31'd1, 1, ST_OK));
    table_rows.push_back(mk(OP_LT, 32'd1, 31'd2, 32'd1, 31'd3, 1, 32'd0, 31'd1, 0, ST_OK));
    table_rows.push_back(mk(OP_MUL, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1, 1,
                            32'd0, 31'd1, 0, ST_OVERFLOW));
    table_rows.push_back(mk(OP_ADD, 32'h8000_0000, 31'd1, 32'd0, 31'd1, 1,
                            32'h8000_0000, 31'd1, 0, ST_OK));
    table_rows.push_back(mk(OP_SUB, 32'h8000_0000, 31'd1, 32'd1, 31'd1, 1,
                            32'd0, 31'd1, 0, ST_OVERFLOW));
    table_rows.push_back(mk(OP_DIV, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1, 1,
                            32'd0, 31'd1, 0, ST_OVERFLOW));
    table_rows.push_back(mk(OP_MUL, 32'd1, 31'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFF, 1,
                            32'd0, 31'd1, 0, ST_OVERFLOW));
    table_rows.push_back(mk(OP_ADD, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000,
                            31'h7FFF_FFFE, 0, '0, '0, 0, ST_OK));
    table_rows.push_back(mk(OP_DIV, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                            31'h7FFF_FFFF, 0, '0, '0, 0, ST_OK));
    table_rows.push_back(mk(OP_GT, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 31'd1, 1,
                            32'd0, 31'd1, 0, ST_OK));
    table_rows.push_back(mk(OP_SUB, 32'd0, 31'd5, 32'd0, 31'd9, 1, 32'd0, 31'd1, 0, ST_OK));
    table_rows.push_back(mk(OP_ADD, 32'hAAAA_5555, 31'h5555_2AAA, 32'h5555_AAAA,
                            31'h2AAA_D555, 0, '0, '0, 0, ST_OK));
    foreach (table_rows[i]) begin
      send_word(table_rows[i]);
      sender_gap();
    end

    // Random words; a long receiver hold fills the block part way through.
    for (int i = 0; i < 700; i++) begin
      if (i == 200) hold_pop = 1'b1;
      if (i == 400) begin
        // Sender pauses until every expected word has come back.
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (i == 600) calm_phase = 1'b1;
      row = random_row();
      row.known = 1'b0;
      send_word(row);
      sender_gap();
    end
    push <= 1'b0;
    sending_done = 1'b1;

    // Drain, then allow for a latency's worth of stray output.
    wait_count = 0;
    while (pending_results.size() != 0 && wait_count < 200000) begin
      @(posedge clk);
      wait_count++;
    end
    if (pending_results.size() != 0) begin
      $display("Timeout with %0d words outstanding", pending_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      repeat (DrainCycles) @(posedge clk);
      $display("Covered %0d words, %0d results checked, including zero denominators,",
               words_sent, words_checked);
      $display("overflow, all eight opcodes, a full-block stall and a drained pause.");
      if (errors == 0) begin
        $display("== PASS ==");
      end else begin
        $display("== FAIL ==");
      end
      $finish;
    end
  end
endmodule
